>>> rtl/receive_reorder_buffer_assert.svh
// Assertion macros used by the receive reorder buffer RTL.
`ifndef RECEIVE_REORDER_BUFFER_ASSERT_SVH
`define RECEIVE_REORDER_BUFFER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("receive_reorder_buffer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RRB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("receive_reorder_buffer: next-cycle check failed");

`endif

>>> rtl/rrb_pkg.sv
// Package with the constants, codes and types of the receive reorder buffer.
package rrb_pkg;

  localparam int DEPTH       = 16;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

  localparam int SEQ_W    = 16;
  localparam int LEN_W    = 16;
  localparam int TAG_W    = 16;
  localparam int BYTES_W  = 20;
  localparam int STATUS_W = 2;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;

  localparam logic [BYTES_W-1:0] WINDOW_RESET   = 20'd65535;
  localparam logic [SEQ_W-1:0]   INIT_SEQ_RESET = 16'd0;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_SEQ = 1'd1;

  localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_ROOM  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OCCUPIED = 2'd2;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [LEN_W-1:0] length;
  } cell_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_ADD  = 3'b010,
    S_REL  = 3'b100
  } state_t;

endpackage

>>> rtl/rrb_cell.sv
// One slot of the reorder chain; it loads a segment or takes its upper neighbor on a shift.
module rrb_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      shift,
  input  logic                      wr_en,
  input  logic [rrb_pkg::TAG_W-1:0] wr_tag,
  input  logic [rrb_pkg::LEN_W-1:0] wr_length,
  input  rrb_pkg::cell_t            nbr,
  output rrb_pkg::cell_t            q
);

  logic                      valid_r, valid_nxt;
  logic [rrb_pkg::TAG_W-1:0] tag_r, tag_nxt;
  logic [rrb_pkg::LEN_W-1:0] length_r, length_nxt;

  always_comb begin
    priority if (shift) begin
      valid_nxt  = nbr.valid;
      tag_nxt    = nbr.tag;
      length_nxt = nbr.length;
    end else if (wr_en) begin
      valid_nxt  = 1'b1;
      tag_nxt    = wr_tag;
      length_nxt = wr_length;
    end else begin
      valid_nxt  = valid_r;
      tag_nxt    = tag_r;
      length_nxt = length_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r    <= tag_nxt;
    length_r <= length_nxt;
  end

  assign q.valid  = valid_r;
  assign q.tag    = tag_r;
  assign q.length = length_r;

endmodule

>>> rtl/receive_reorder_buffer.sv
// Receive reorder buffer top level: control, window accounting and the chain of slot cells.
//
// Segments are held in a chain of DEPTH cells ordered by distance from the expected
// sequence number; cell zero always holds the expected segment. An item is taken in
// the idle state, checked and stored in the add state, and then the chain shifts down
// by one cell per released segment, one result per cycle while the output is not
// stalled. Results leave through the single output register, one per released segment,
// or a single one when an item releases none. At most 16 segments are released per
// item; any remainder goes out with the following items. New items are taken only
// between runs; the last result of a run may still wait in the output register while
// the next item is taken.
module receive_reorder_buffer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [rrb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rrb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // Fields from bit 0: segment_seq, segment_length, segment_tag.
  input  logic [rrb_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // Fields from bit 0: add_status, release_seq, release_tag, zero fill.
  output logic [rrb_pkg::OUT_DATA_W-1:0] out_tdata,
  // Fields from bit 0: release_valid.
  output logic                           out_tuser,
  output logic                           out_tlast
);

`include "receive_reorder_buffer_assert.svh"

  rrb_pkg::state_t state_r, state_nxt;

  logic [rrb_pkg::SEQ_W-1:0]    seg_seq_r, seg_seq_nxt;
  logic [rrb_pkg::LEN_W-1:0]    seg_len_r, seg_len_nxt;
  logic [rrb_pkg::TAG_W-1:0]    seg_tag_r, seg_tag_nxt;
  logic [rrb_pkg::SEQ_W-1:0]    expected_r, expected_nxt;
  logic [rrb_pkg::BYTES_W-1:0]  bytes_r, bytes_nxt;
  logic [rrb_pkg::BYTES_W-1:0]  window_r, window_nxt;
  logic [rrb_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [rrb_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [rrb_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                         out_rel_r, out_rel_nxt;
  logic [rrb_pkg::SEQ_W-1:0]    out_seq_r, out_seq_nxt;
  logic [rrb_pkg::TAG_W-1:0]    out_tag_r, out_tag_nxt;
  logic                         out_last_r, out_last_nxt;

  rrb_pkg::cell_t               cells_q [rrb_pkg::DEPTH];
  logic [rrb_pkg::DEPTH-1:0]    vld;
  logic [rrb_pkg::DEPTH-1:0]    wr_en;
  logic                         shift;
  logic                         add_ok;
  logic [rrb_pkg::SEQ_W-1:0]    offset;
  logic [rrb_pkg::IDX_W-1:0]    slot_idx;
  logic                         in_win;
  logic                         room;
  logic                         can_out;
  logic                         run_last;

  assign in_tready = (state_r == rrb_pkg::S_IDLE);
  assign can_out   = !out_valid_r || out_tready;

  assign offset   = seg_seq_r - expected_r;
  assign slot_idx = offset[rrb_pkg::IDX_W-1:0];
  assign in_win   = (offset < rrb_pkg::SEQ_W'(rrb_pkg::DEPTH));
  assign room     = ({1'b0, bytes_r} + {5'd0, seg_len_r}) <= {1'b0, window_r};
  assign add_ok   = (state_r == rrb_pkg::S_ADD) && in_win && room && !vld[slot_idx];
  assign shift    = (state_r == rrb_pkg::S_REL) && can_out && cells_q[0].valid;
  assign run_last = (cnt_r == rrb_pkg::CNT_W'(rrb_pkg::MAX_RESULTS - 1)) || !cells_q[1].valid;

  for (genvar k = 0; k < rrb_pkg::DEPTH; k++) begin : g_cell
    rrb_pkg::cell_t nbr;
    if (k == rrb_pkg::DEPTH - 1) begin : g_top
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cells_q[k+1];
    end
    assign vld[k]   = cells_q[k].valid;
    assign wr_en[k] = add_ok && (slot_idx == rrb_pkg::IDX_W'(k));
    rrb_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift     (shift),
      .wr_en     (wr_en[k]),
      .wr_tag    (seg_tag_r),
      .wr_length (seg_len_r),
      .nbr       (nbr),
      .q         (cells_q[k])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    seg_seq_nxt    = seg_seq_r;
    seg_len_nxt    = seg_len_r;
    seg_tag_nxt    = seg_tag_r;
    expected_nxt   = expected_r;
    bytes_nxt      = bytes_r;
    window_nxt     = window_r;
    status_nxt     = status_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_rel_nxt    = out_rel_r;
    out_seq_nxt    = out_seq_r;
    out_tag_nxt    = out_tag_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      rrb_pkg::S_IDLE: begin
        if (in_tvalid) begin
          seg_seq_nxt = in_tdata[15:0];
          seg_len_nxt = in_tdata[31:16];
          seg_tag_nxt = in_tdata[47:32];
          state_nxt   = rrb_pkg::S_ADD;
        end
      end
      rrb_pkg::S_ADD: begin
        priority if (!in_win || !room) begin
          status_nxt = rrb_pkg::ST_NO_ROOM;
        end else if (vld[slot_idx]) begin
          status_nxt = rrb_pkg::ST_OCCUPIED;
        end else begin
          status_nxt = rrb_pkg::ST_ACCEPTED;
          bytes_nxt  = bytes_r + {4'd0, seg_len_r};
        end
        cnt_nxt   = '0;
        state_nxt = rrb_pkg::S_REL;
      end
      rrb_pkg::S_REL: begin
        if (can_out) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          if (cells_q[0].valid) begin
            out_rel_nxt  = 1'b1;
            out_seq_nxt  = expected_r;
            out_tag_nxt  = cells_q[0].tag;
            out_last_nxt = run_last;
            bytes_nxt    = bytes_r - {4'd0, cells_q[0].length};
            expected_nxt = expected_r + 16'd1;
            cnt_nxt      = cnt_r + 1'b1;
            if (run_last) begin
              state_nxt = rrb_pkg::S_IDLE;
            end
          end else begin
            out_rel_nxt  = 1'b0;
            out_seq_nxt  = '0;
            out_tag_nxt  = '0;
            out_last_nxt = 1'b1;
            state_nxt    = rrb_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = rrb_pkg::S_IDLE;
      end
    endcase

    if (cfg_wr_en) begin
      if (cfg_index == rrb_pkg::REG_WINDOW) begin
        window_nxt = cfg_wdata;
      end else if (cfg_index == rrb_pkg::REG_INIT_SEQ) begin
        if (!(|vld)) begin
          expected_nxt = cfg_wdata[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rrb_pkg::S_IDLE;
      expected_r  <= rrb_pkg::INIT_SEQ_RESET;
      bytes_r     <= '0;
      window_r    <= rrb_pkg::WINDOW_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      expected_r  <= expected_nxt;
      bytes_r     <= bytes_nxt;
      window_r    <= window_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seg_seq_r    <= seg_seq_nxt;
    seg_len_r    <= seg_len_nxt;
    seg_tag_r    <= seg_tag_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_rel_r    <= out_rel_nxt;
    out_seq_r    <= out_seq_nxt;
    out_tag_r    <= out_tag_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_tag_r, out_seq_r, out_status_r};
  assign out_tuser  = out_rel_r;
  assign out_tlast  = out_last_r;

  `RRB_ASSERT_NEXT(a_add_then_release, state_r == rrb_pkg::S_ADD, state_r == rrb_pkg::S_REL)
  `RRB_ASSERT_NEXT(a_shift_advances, shift, expected_r == $past(expected_r) + 16'd1)
  `RRB_ASSERT_NOW(a_empty_is_last, out_valid_r && !out_rel_r, out_last_r)

endmodule

>>> dv/receive_reorder_buffer_tb.sv
// Self-checking testbench for the receive reorder buffer with a built-in in-order release predictor.
module receive_reorder_buffer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rrb_pkg::*;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
    logic [TAG_W-1:0] tag;
  } segment_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                rel_valid;
    logic [SEQ_W-1:0]    seq;
    logic [TAG_W-1:0]    tag;
    logic                last;
  } release_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  segment_t    pend_q[$];
  release_t    release_q[$];
  int unsigned items_shown    = 0;
  int unsigned items_taken    = 0;
  int unsigned n_items        = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors         = 0;
  int unsigned short_len_max  = 2000;

  logic             held_valid[DEPTH];
  logic [TAG_W-1:0] held_tag[DEPTH];
  logic [LEN_W-1:0] held_len[DEPTH];
  logic [SEQ_W-1:0] next_seq;
  logic [SEQ_W-1:0] init_seq;
  int unsigned      ring_head;
  int unsigned      held_bytes;
  int unsigned      win_bytes;

  receive_reorder_buffer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #2 clk = ~clk;

  function automatic logic store_empty();
    for (int i = 0; i < DEPTH; i++) begin
      if (held_valid[i]) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic reorder_predict(input logic [SEQ_W-1:0] seq, input logic [LEN_W-1:0] len,
                                 input logic [TAG_W-1:0] tag);
    logic [SEQ_W-1:0]    offset;
    logic [STATUS_W-1:0] status;
    int unsigned         slot;
    int                  n;
    release_t            r;
    offset = seq - next_seq;
    if (offset >= DEPTH || held_bytes + len > win_bytes) begin
      status = ST_NO_ROOM;
    end else begin
      slot = (ring_head + offset) % DEPTH;
      if (held_valid[slot]) begin
        status = ST_OCCUPIED;
      end else begin
        held_valid[slot] = 1'b1;
        held_tag[slot]   = tag;
        held_len[slot]   = len;
        held_bytes       = held_bytes + len;
        status           = ST_ACCEPTED;
      end
    end
    n = 0;
    r = '0;
    while (n < MAX_RESULTS && held_valid[ring_head]) begin
      if (n > 0) begin
        release_q = {release_q, r};
      end
      r.status    = status;
      r.rel_valid = 1'b1;
      r.seq       = next_seq;
      r.tag       = held_tag[ring_head];
      r.last      = 1'b0;
      held_valid[ring_head] = 1'b0;
      held_bytes = held_bytes - held_len[ring_head];
      next_seq   = next_seq + 1'b1;
      ring_head  = (ring_head + 1) % DEPTH;
      n++;
    end
    if (n == 0) begin
      r        = '0;
      r.status = status;
    end
    r.last = 1'b1;
    release_q = {release_q, r};
  endtask

  always @(posedge clk) begin : monitor
    release_t got;
    release_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.status    = out_tdata[STATUS_W-1:0];
        got.rel_valid = out_tuser;
        got.seq       = out_tdata[STATUS_W +: SEQ_W];
        got.tag       = out_tdata[STATUS_W+SEQ_W +: TAG_W];
        got.last      = out_tlast;
        if (release_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected result: status %0d valid %0b seq %0d tag %0d last %0b",
                     got.status, got.rel_valid, got.seq, got.tag, got.last);
          end
        end else begin
          want = release_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: expected status %0d valid %0b seq %0d tag %0d last %0b",
                       want.status, want.rel_valid, want.seq, want.tag, want.last);
              $display("          actual   status %0d valid %0b seq %0d tag %0d last %0b",
                       got.status, got.rel_valid, got.seq, got.tag, got.last);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        reorder_predict(in_tdata[15:0], in_tdata[31:16], in_tdata[47:32]);
        items_taken++;
      end
    end
  end

  always @(negedge clk) begin : driver
    segment_t seg;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (items_taken == items_shown) begin
      if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        seg = pend_q.pop_front();
        in_tdata  <= {seg.tag, seg.len, seg.seq};
        in_tvalid <= 1'b1;
        items_shown++;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    if (idx == REG_WINDOW) begin
      win_bytes = value & 32'hFFFFF;
    end else if (idx == REG_INIT_SEQ) begin
      init_seq = value[SEQ_W-1:0];
      if (store_empty()) begin
        next_seq = init_seq;
      end
    end
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic push_seg(input logic [SEQ_W-1:0] seq, input logic [LEN_W-1:0] len,
                          input logic [TAG_W-1:0] tag);
    segment_t seg;
    seg.seq = seq;
    seg.len = len;
    seg.tag = tag;
    pend_q = {pend_q, seg};
    n_items++;
  endtask

  task automatic wait_taken();
    do @(negedge clk); while (pend_q.size() != 0 || items_taken != items_shown);
  endtask

  task automatic settle();
    wait_taken();
    while (release_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct  = 62;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = 62;
      end
      default: begin
        send_idle_pct  = 25;
        recv_stall_pct = 25;
      end
    endcase
  endtask

  function automatic logic [LEN_W-1:0] pick_len();
    if ($urandom_range(99) < 5) begin
      return LEN_W'($urandom_range(65535));
    end
    return LEN_W'($urandom_range(short_len_max));
  endfunction

  // Fills every gap below the highest held segment so the store drains completely.
  task automatic fill_holes();
    int top;
    wait_taken();
    top = -1;
    for (int off = 0; off < DEPTH; off++) begin
      if (held_valid[(ring_head + off) % DEPTH]) begin
        top = off;
      end
    end
    for (int off = 0; off < top; off++) begin
      if (!held_valid[(ring_head + off) % DEPTH]) begin
        push_seg(next_seq + SEQ_W'(off), '0, TAG_W'($urandom));
      end
    end
  endtask

  task automatic random_batch();
    logic [SEQ_W-1:0] base;
    int               order[DEPTH];
    int               k;
    int               j;
    int               t;
    wait_taken();
    base = next_seq;
    if ($urandom_range(99) < 80) begin
      k = $urandom_range(DEPTH, 1);
      for (int i = 0; i < k; i++) begin
        order[i] = i;
      end
      for (int i = k - 1; i > 0; i--) begin
        j = $urandom_range(i);
        t = order[i];
        order[i] = order[j];
        order[j] = t;
      end
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(99) < 8) begin
          continue;
        end
        push_seg(base + SEQ_W'(order[i]), pick_len(), TAG_W'($urandom));
        if ($urandom_range(99) < 8) begin
          push_seg(base + SEQ_W'(order[i]), pick_len(), TAG_W'($urandom));
        end
      end
    end else begin
      case ($urandom_range(2))
        0: push_seg(base + SEQ_W'(DEPTH), pick_len(), TAG_W'($urandom));
        1: push_seg(base - 1'b1, pick_len(), TAG_W'($urandom));
        default: push_seg(SEQ_W'($urandom), LEN_W'($urandom), TAG_W'($urandom));
      endcase
    end
  endtask

  initial begin : stimulus
    logic [SEQ_W-1:0] base;
    int unsigned      goal;
    int unsigned      window;
    int unsigned      start_seq;
    for (int i = 0; i < DEPTH; i++) begin
      held_valid[i] = 1'b0;
      held_tag[i]   = '0;
      held_len[i]   = '0;
    end
    win_bytes  = WINDOW_RESET;
    init_seq   = INIT_SEQ_RESET;
    next_seq   = INIT_SEQ_RESET;
    ring_head  = 0;
    held_bytes = 0;
    set_idling(IDLE_NONE);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    cfg_write(REG_WINDOW, 1048575);
    cfg_write(REG_INIT_SEQ, 65530);
    base = next_seq;
    push_seg(base, 16'd0, 16'h0000);
    push_seg(base + 16'd2, 16'hFFFF, 16'hFFFF);
    push_seg(base + 16'd2, 16'hFFFF, 16'h1234);
    push_seg(base + 16'd17, 16'd1, 16'hAAAA);
    push_seg(base, 16'd5, 16'h5555);
    for (int off = 3; off <= 16; off++) begin
      push_seg(base + SEQ_W'(off), 16'hFFFF, 16'h8000 | TAG_W'(off));
    end
    push_seg(base + 16'd1, 16'hFFFF, 16'h7FFF);
    settle();

    base = next_seq;
    push_seg(base + 16'd1, 16'd100, 16'h5A5A);
    settle();
    cfg_write(REG_WINDOW, 50);
    cfg_write(REG_INIT_SEQ, 1234);
    push_seg(base, 16'd0, 16'h0F0F);
    settle();
    cfg_write(REG_WINDOW, 200);
    push_seg(base, 16'd0, 16'hA5A5);
    settle();
    cfg_write(REG_WINDOW, 0);
    base = next_seq;
    push_seg(base, 16'd0, 16'hC3C3);
    push_seg(base + 16'd1, 16'd1, 16'h3C3C);
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      set_idling(idle_mode_t'(ph % 4));
      short_len_max = 2000;
      case (ph)
        0, 4: window = 65535;
        1: window = $urandom_range(1048575, 100000);
        2, 6: begin
          window = $urandom_range(8000, 2000);
          short_len_max = 300;
        end
        5: window = $urandom_range(200000, 20000);
        default: window = 1048575;
      endcase
      case (ph)
        3: start_seq = 65535;
        4: start_seq = 0;
        default: start_seq = $urandom_range(65535);
      endcase
      cfg_write(REG_WINDOW, window);
      cfg_write(REG_INIT_SEQ, start_seq);
      goal = n_items + 36;
      while (n_items < goal) begin
        random_batch();
      end
      fill_holes();
      settle();
    end

    repeat (20) @(negedge clk);
    errors += release_q.size();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
